// ===== rtl/tracker_song_row_walker_unit_assert.svh =====
// Assertion macros for the row walker.
`ifndef TRACKER_SONG_ROW_WALKER_UNIT_ASSERT_SVH
`define TRACKER_SONG_ROW_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TSRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TSRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsrw_pkg.sv =====
package tsrw_pkg;

  localparam int NUM_CHANNELS     = 4;
  localparam int ROWS_PER_PATTERN = 64;
  localparam int NUM_POSITIONS    = 128;

  localparam int ROW_W    = $clog2(ROWS_PER_PATTERN);
  localparam int POS_W    = $clog2(NUM_POSITIONS);
  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TALLY_W  = 24;
  localparam int LOOPS_W  = 7;
  localparam int CMD_W    = 4;
  localparam int PRM_W    = 8;
  localparam int REM_W    = 4;
  localparam int LEN_W    = 8;
  localparam int LCNT_W   = 6;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT  = 1'b1;

  localparam logic [CMD_W-1:0] CMD_JUMP  = 4'hB;
  localparam logic [CMD_W-1:0] CMD_BREAK = 4'hD;
  localparam logic [CMD_W-1:0] CMD_EXT   = 4'hE;
  localparam logic [CMD_W-1:0] CMD_STOP  = 4'hF;
  localparam logic [3:0]       EXT_LOOP  = 4'h6;

  localparam logic [PRM_W-1:0] BREAK_MAX = 8'd63;
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [CMD_W-1:0] ch0_command;
    logic [PRM_W-1:0] ch0_param;
    logic [CMD_W-1:0] ch1_command;
    logic [PRM_W-1:0] ch1_param;
    logic [CMD_W-1:0] ch2_command;
    logic [PRM_W-1:0] ch2_param;
    logic [CMD_W-1:0] ch3_command;
    logic [PRM_W-1:0] ch3_param;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]   next_position;
    logic [ROW_W-1:0]   next_row;
    logic [TALLY_W-1:0] rows_total;
    logic               done_res;
  } result_t;

  // decimal break row: hi*10 + lo, zero when above the last row
  function automatic logic [ROW_W-1:0] break_value(input logic [PRM_W-1:0] prm);
    logic [PRM_W-1:0] v;
    v = {1'b0, prm[7:4], 3'b000} + {3'b000, prm[7:4], 1'b0} + {4'b0000, prm[3:0]};
    if (v > BREAK_MAX) begin
      return '0;
    end
    return v[ROW_W-1:0];
  endfunction

endpackage

// ===== rtl/tsrw_ram.sv =====
module tsrw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tracker_song_row_walker_unit.sv =====
// Row item steps: map mark, channel scan one channel at a time, final step, map test,
// result; a pattern-loop row clear adds a read and a write, a full map clear covers all
// 128 entries; an ended walk goes straight to the result, a restart clears the map
// first. One item at a time: the next item beat comes no earlier than the cycle after
// the result beat; the channel scan and the map RAM's shared address set this.
// Reset (rst, synchronous) clears all 128 map entries, item_stall high; config taken.
module tracker_song_row_walker_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [tsrw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsrw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tsrw_pkg::item_t                     item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output tsrw_pkg::result_t                   res
);

  localparam int ROW_W = tsrw_pkg::ROW_W;
  localparam int POS_W = tsrw_pkg::POS_W;
  localparam int CH_W  = tsrw_pkg::CH_W;
  localparam int NCH   = tsrw_pkg::NUM_CHANNELS;
  localparam int ROWS  = tsrw_pkg::ROWS_PER_PATTERN;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MARK_RD, S_MARK_WR, S_SCAN, S_LCLR_RD, S_LCLR_WR,
    S_FINAL, S_TEST_RD, S_TEST_CHK, S_OUT
  } state_t;

  typedef enum logic [1:0] {RET_IDLE, RET_SCAN, RET_FINAL, RET_OUT} ret_t;

  state_t state;
  ret_t   ret;
  state_t ret_st;
  state_t scan_next;

  logic [tsrw_pkg::LEN_W-1:0]   song_length;
  logic [tsrw_pkg::LCNT_W-1:0]  loop_count;
  logic [POS_W-1:0]             position;
  logic [ROW_W-1:0]             row;
  logic [tsrw_pkg::LOOPS_W-1:0] loops_left;
  logic [ROW_W-1:0]             loop_start_row [NCH];
  logic [tsrw_pkg::REM_W-1:0]   loop_remaining [NCH];
  logic [tsrw_pkg::TALLY_W-1:0] row_tally;
  logic                         finished;

  tsrw_pkg::item_t  item_q;
  logic [CH_W-1:0]  ch;
  logic [ROW_W-1:0] target;
  logic             jump;
  logic             loop_jump;
  logic [ROW_W-1:0] lcl_from;
  logic [POS_W-1:0] map_addr;

  logic             map_we;
  logic [ROWS-1:0]  map_wdata;
  logic [ROWS-1:0]  map_rdata;

  logic [tsrw_pkg::CMD_W-1:0] cmds [NCH];
  logic [tsrw_pkg::PRM_W-1:0] prms [NCH];
  logic [tsrw_pkg::CMD_W-1:0] cmd;
  logic [tsrw_pkg::PRM_W-1:0] prm;
  logic                       is_jump, is_break, is_stop, is_loop;
  logic [ROW_W-1:0]           start_sel;
  logic [tsrw_pkg::REM_W-1:0] rem_sel, rem_dec;
  logic                       last_ch;

  logic [ROW_W:0]   next_seq, nxt;
  logic [ROW_W-1:0] tgt, new_row;
  logic             adv, len_end;
  logic [POS_W-1:0] pos_inc;
  logic [ROWS-1:0]  clr_range;

  logic             take_restart;

  assign cmds[0] = item_q.ch0_command;
  assign prms[0] = item_q.ch0_param;
  assign cmds[1] = item_q.ch1_command;
  assign prms[1] = item_q.ch1_param;
  assign cmds[2] = item_q.ch2_command;
  assign prms[2] = item_q.ch2_param;
  assign cmds[3] = item_q.ch3_command;
  assign prms[3] = item_q.ch3_param;

  // per-channel decode, one channel a cycle unless a map clear or row clear holds the scan
  always_comb begin
    cmd       = cmds[ch];
    prm       = prms[ch];
    is_jump   = (cmd == tsrw_pkg::CMD_JUMP);
    is_break  = (cmd == tsrw_pkg::CMD_BREAK);
    is_stop   = (cmd == tsrw_pkg::CMD_STOP) && (prm == '0);
    is_loop   = (cmd == tsrw_pkg::CMD_EXT) && (prm[7:4] == tsrw_pkg::EXT_LOOP);
    start_sel = loop_start_row[ch];
    rem_sel   = loop_remaining[ch];
    rem_dec   = rem_sel - 1'b1;
    last_ch   = (ch == CH_W'(NCH - 1));
    scan_next = last_ch ? S_FINAL : S_SCAN;
  end

  // end-of-row step
  always_comb begin
    next_seq = {1'b0, row} + 1'b1;
    nxt      = loop_jump ? {1'b0, target} : next_seq;
    tgt      = loop_jump ? '0 : target;
    adv      = nxt[ROW_W] || jump;
    new_row  = adv ? tgt : nxt[ROW_W-1:0];
    pos_inc  = position + 1'b1;
    len_end  = adv && ({1'b0, pos_inc} >= song_length);
  end

  always_comb begin
    case (ret)
      RET_IDLE:  ret_st = S_IDLE;
      RET_SCAN:  ret_st = S_SCAN;
      RET_FINAL: ret_st = S_FINAL;
      RET_OUT:   ret_st = S_OUT;
      default:   ret_st = S_OUT;
    endcase
  end

  always_comb begin
    clr_range = ({ROWS{1'b1}} << lcl_from) & ({ROWS{1'b1}} >> (ROW_W'(ROWS - 1) - row));
    map_we    = 1'b0;
    map_wdata = '0;
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
      end
      S_MARK_WR: begin
        map_we    = 1'b1;
        map_wdata = map_rdata | (ROWS'(1) << row);
      end
      S_LCLR_WR: begin
        map_we    = 1'b1;
        map_wdata = map_rdata & ~clr_range;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  tsrw_ram #(
    .WIDTH (ROWS),
    .DEPTH (tsrw_pkg::NUM_POSITIONS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_addr),
    .wdata (map_wdata),
    .raddr (map_addr),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      ret         <= RET_IDLE;
      map_addr    <= '0;
      song_length <= tsrw_pkg::LEN_W'(1);
      loop_count  <= '0;
      position    <= '0;
      row         <= '0;
      loops_left  <= '0;
      row_tally   <= '0;
      finished    <= 1'b0;
      ch          <= '0;
      target      <= '0;
      jump        <= 1'b0;
      loop_jump   <= 1'b0;
      lcl_from    <= '0;
      for (int i = 0; i < NCH; i++) begin
        loop_start_row[i] <= '0;
        loop_remaining[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          tsrw_pkg::REG_SONG_LENGTH: song_length <= cfg_data;
          tsrw_pkg::REG_LOOP_COUNT:  loop_count  <= cfg_data[tsrw_pkg::LCNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          map_addr <= map_addr + 1'b1;
          if (map_addr == POS_W'(tsrw_pkg::NUM_POSITIONS - 1)) begin
            state <= ret_st;
          end
        end

        S_IDLE: begin
          if (item_valid) begin
            item_q    <= item;
            ch        <= '0;
            target    <= '0;
            jump      <= 1'b0;
            loop_jump <= 1'b0;
            if (item.kind) begin
              position   <= '0;
              row        <= '0;
              loops_left <= {1'b0, loop_count};
              row_tally  <= '0;
              finished   <= 1'b0;
              for (int i = 0; i < NCH; i++) begin
                loop_start_row[i] <= '0;
                loop_remaining[i] <= '0;
              end
              map_addr <= '0;
              ret      <= RET_OUT;
              state    <= S_CLEAR;
            end else if (finished) begin
              state <= S_OUT;
            end else begin
              map_addr <= position;
              state    <= S_MARK_RD;
            end
          end
        end

        S_MARK_RD: state <= S_MARK_WR;
        S_MARK_WR: state <= S_SCAN;

        S_SCAN: begin
          ch <= ch + 1'b1;
          if (is_jump) begin
            position <= prm[POS_W-1:0] - 1'b1;
            target   <= '0;
            jump     <= 1'b1;
            state    <= scan_next;
          end else if (is_break) begin
            target <= tsrw_pkg::break_value(prm);
            jump   <= 1'b1;
            state  <= scan_next;
          end else if (is_stop) begin
            if (loops_left == '0) begin
              finished <= 1'b1;
              state    <= S_FINAL;
            end else begin
              loops_left <= loops_left - 1'b1;
              map_addr   <= '0;
              ret        <= last_ch ? RET_FINAL : RET_SCAN;
              state      <= S_CLEAR;
            end
          end else if (is_loop) begin
            if (prm[3:0] == '0) begin
              loop_start_row[ch] <= row;
              state              <= scan_next;
            end else if (rem_sel == '0 || rem_dec != '0) begin
              loop_remaining[ch] <= (rem_sel == '0) ? prm[3:0] : rem_dec;
              target             <= start_sel;
              loop_jump          <= 1'b1;
              if (start_sel <= row) begin
                lcl_from <= start_sel;
                map_addr <= position;
                ret      <= last_ch ? RET_FINAL : RET_SCAN;
                state    <= S_LCLR_RD;
              end else begin
                state <= scan_next;
              end
            end else begin
              loop_remaining[ch] <= rem_dec;
              state              <= scan_next;
            end
          end else begin
            state <= scan_next;
          end
        end

        S_LCLR_RD: state <= S_LCLR_WR;
        S_LCLR_WR: state <= ret_st;

        S_FINAL: begin
          row <= new_row;
          if (row_tally != tsrw_pkg::TALLY_MAX) begin
            row_tally <= row_tally + 1'b1;
          end
          if (adv) begin
            position <= len_end ? '0 : pos_inc;
          end
          if (len_end) begin
            if (loops_left == '0) begin
              finished <= 1'b1;
              state    <= S_OUT;
            end else begin
              loops_left <= loops_left - 1'b1;
              map_addr   <= '0;
              ret        <= RET_OUT;
              state      <= S_CLEAR;
            end
          end else if (finished) begin
            state <= S_OUT;
          end else begin
            map_addr <= adv ? pos_inc : position;
            state    <= S_TEST_RD;
          end
        end

        S_TEST_RD: state <= S_TEST_CHK;

        S_TEST_CHK: begin
          if (map_rdata[row]) begin
            if (loops_left == '0) begin
              finished <= 1'b1;
              state    <= S_OUT;
            end else begin
              loops_left <= loops_left - 1'b1;
              map_addr   <= '0;
              ret        <= RET_OUT;
              state      <= S_CLEAR;
            end
          end else begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!res_stall) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_stall = (state != S_IDLE);
  assign res_valid  = (state == S_OUT);
  assign res        = '{next_position: position, next_row: row,
                        rows_total: row_tally, done_res: finished};

  assign take_restart = item_valid && !item_stall && item.kind;

`include "tracker_song_row_walker_unit_assert.svh"

  `TSRW_ASSERT_NOW(a_busy_while_result, res_valid, item_stall, "item taken with result pending")
  `TSRW_ASSERT_NOW(a_clear_writes_zero, state == S_CLEAR, map_we && map_wdata == '0, "bad clear")
  `TSRW_ASSERT_NEXT(a_restart_clears, take_restart, state == S_CLEAR, "restart skipped clear")
  `TSRW_ASSERT_NEXT(a_done_sticks, finished && !take_restart, finished, "walk end lost")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tsrw_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic res_valid;
  logic res_stall;
  result_t res;

  tracker_song_row_walker_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  // shadow of the walker
  logic [LEN_W-1:0] song_len_cfg;
  logic [LCNT_W-1:0] loop_cnt_cfg;
  logic [POS_W-1:0] pl_pos;
  logic [ROW_W-1:0] pl_row;
  logic [LOOPS_W-1:0] pl_loops;
  logic [ROW_W-1:0] pl_loop_start [NUM_CHANNELS];
  logic [REM_W-1:0] pl_loop_rem [NUM_CHANNELS];
  logic [NUM_POSITIONS*ROWS_PER_PATTERN-1:0] pl_seen;
  logic [TALLY_W-1:0] pl_rows;
  logic pl_done;

  result_t walk_results_due[$];
  int mismatches = 0;

  typedef struct {
    bit set_cfg;
    logic [7:0] len_v;
    logic [7:0] lc_v;
    item_t stim;
    bit typed;
    result_t want;
  } dir_step_t;

  dir_step_t plan[$];

  function automatic void add_step(bit set_cfg, logic [7:0] len_v, logic [7:0] lc_v,
                                   item_t stim, bit typed, result_t want);
    dir_step_t s;
    s.set_cfg = set_cfg;
    s.len_v = len_v;
    s.lc_v = lc_v;
    s.stim = stim;
    s.typed = typed;
    s.want = want;
    plan.push_back(s);
  endfunction

  function automatic void start_walk();
    pl_pos = '0;
    pl_row = '0;
    pl_loops = loop_cnt_cfg;
    foreach (pl_loop_start[i]) begin
      pl_loop_start[i] = '0;
      pl_loop_rem[i] = '0;
    end
    pl_seen = '0;
    pl_rows = '0;
    pl_done = 1'b0;
  endfunction

  function automatic void end_of_song();
    if (pl_loops == 0) begin
      pl_done = 1'b1;
    end else begin
      pl_loops = pl_loops - 1'b1;
      pl_seen = '0;
    end
  endfunction

  function automatic void forget_rows(int from, int upto);
    for (int r = from; r <= upto && r < ROWS_PER_PATTERN; r++) begin
      pl_seen[{pl_pos, r[ROW_W-1:0]}] = 1'b0;
    end
  endfunction

  task automatic advance_walk(input item_t it, output result_t r);
    logic [CMD_W-1:0] cmd [NUM_CHANNELS];
    logic [PRM_W-1:0] prm [NUM_CHANNELS];
    int target;
    int nxt;
    bit jump;
    bit loop_jump;
    bit ended;
    cmd[0] = it.ch0_command; prm[0] = it.ch0_param;
    cmd[1] = it.ch1_command; prm[1] = it.ch1_param;
    cmd[2] = it.ch2_command; prm[2] = it.ch2_param;
    cmd[3] = it.ch3_command; prm[3] = it.ch3_param;
    if (it.kind) begin
      start_walk();
    end else if (!pl_done) begin
      target = 0;
      jump = 1'b0;
      loop_jump = 1'b0;
      ended = 1'b0;
      pl_seen[{pl_pos, pl_row}] = 1'b1;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (cmd[ch] == CMD_JUMP) begin
          pl_pos = prm[ch] - 1;
          target = 0;
          jump = 1'b1;
        end else if (cmd[ch] == CMD_BREAK) begin
          target = prm[ch][7:4] * 10 + prm[ch][3:0];
          if (target > 63) target = 0;
          jump = 1'b1;
        end else if (cmd[ch] == CMD_STOP && prm[ch] == 0) begin
          end_of_song();
          if (pl_done) break;
        end else if (cmd[ch] == CMD_EXT && prm[ch][7:4] == EXT_LOOP) begin
          if (prm[ch][3:0] == 0) begin
            pl_loop_start[ch] = pl_row;
          end else if (pl_loop_rem[ch] == 0) begin
            pl_loop_rem[ch] = prm[ch][3:0];
            target = pl_loop_start[ch];
            loop_jump = 1'b1;
            forget_rows(target, pl_row);
          end else begin
            pl_loop_rem[ch] = pl_loop_rem[ch] - 1'b1;
            if (pl_loop_rem[ch] != 0) begin
              target = pl_loop_start[ch];
              loop_jump = 1'b1;
              forget_rows(target, pl_row);
            end
          end
        end
      end
      nxt = pl_row + 1;
      if (pl_rows != TALLY_MAX) pl_rows = pl_rows + 1'b1;
      if (loop_jump) begin
        nxt = target;
        target = 0;
      end
      if (nxt >= ROWS_PER_PATTERN || jump) begin
        nxt = target;
        pl_pos = pl_pos + 1'b1;
        pl_row = nxt[ROW_W-1:0];
        if (pl_pos >= song_len_cfg) begin
          pl_pos = '0;
          end_of_song();
          ended = pl_done;
        end
      end
      if (!ended) begin
        pl_row = nxt[ROW_W-1:0];
        if (!pl_done && pl_seen[{pl_pos, pl_row}]) end_of_song();
      end
    end
    r.next_position = pl_pos;
    r.next_row = pl_row;
    r.rows_total = pl_rows;
    r.done_res = pl_done;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t compose_row();
    logic [CMD_W-1:0] c [NUM_CHANNELS];
    logic [PRM_W-1:0] p [NUM_CHANNELS];
    logic kind;
    int r;
    int hi;
    int lo;
    kind = pl_done ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 49) == 0);
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      r = $urandom_range(0, 99);
      p[ch] = $urandom;
      if (kind || r < 70) begin
        c[ch] = $urandom_range(0, 15);
        if (c[ch] == CMD_JUMP || c[ch] == CMD_BREAK) c[ch] = $urandom_range(0, 10);
        if (c[ch] == CMD_STOP && p[ch] == 0) p[ch] = 8'h01;
        if (c[ch] == CMD_EXT && p[ch][7:4] == EXT_LOOP) p[ch][7:4] = 4'h7;
      end else if (r < 78) begin
        c[ch] = CMD_JUMP;
        if ($urandom_range(0, 1) == 0) begin
          p[ch] = $urandom_range(0, (song_len_cfg > 0) ? song_len_cfg - 1 : 0);
        end
      end else if (r < 86) begin
        c[ch] = CMD_BREAK;
        if ($urandom_range(0, 1) == 0) begin
          hi = $urandom_range(0, 6);
          lo = $urandom_range(0, 9);
          p[ch] = {hi[3:0], lo[3:0]};
        end
      end else if (r < 98) begin
        c[ch] = CMD_EXT;
        r = $urandom_range(0, 99);
        lo = (r < 40) ? 0 : (r < 80) ? $urandom_range(1, 3) : $urandom_range(1, 15);
        p[ch] = {EXT_LOOP, lo[3:0]};
      end else begin
        c[ch] = CMD_STOP;
        p[ch] = 8'h00;
      end
    end
    return {kind, c[0], p[0], c[1], p[1], c[2], p[2], c[3], p[3]};
  endfunction

  task automatic offer(input item_t it, input bit typed, input result_t want);
    int gap;
    result_t got;
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_walk(it, got);
    walk_results_due.push_back(typed ? want : got);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] len_v, input logic [7:0] lc_v);
    drain();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_SONG_LENGTH;
    cfg_data <= len_v;
    @(negedge clk);
    cfg_index <= REG_LOOP_COUNT;
    cfg_data <= lc_v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    song_len_cfg = len_v;
    loop_cnt_cfg = lc_v[LCNT_W-1:0];
  endtask

  initial begin : stall_gen
    int free;
    int held;
    res_stall = 1'b0;
    forever begin
      free = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      held = idle_len();
      repeat (free) @(negedge clk);
      if (held != 0) begin
        res_stall <= 1'b1;
        repeat (held) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (walk_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", res);
      end else begin
        want = walk_results_due.pop_front();
        if (res.next_position !== want.next_position || res.next_row !== want.next_row ||
            res.rows_total !== want.rows_total || res.done_res !== want.done_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t result mismatch: pos exp %0d got %0d, row exp %0d got %0d",
                     $time, want.next_position, res.next_position, want.next_row,
                     res.next_row);
            $display("  total exp %0d got %0d, done exp %0b got %0b",
                     want.rows_total, res.rows_total, want.done_res, res.done_res);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] len_v;
    logic [7:0] lc_v;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    song_len_cfg = 8'd1;
    loop_cnt_cfg = '0;
    start_walk();

    add_step(0, 0, 0, {1'b0, 48'h0}, 1, {7'd0, 6'd1, 24'd1, 1'b0});
    add_step(0, 0, 0, {1'b0, CMD_BREAK, 8'h99, 36'h0}, 1, {7'd0, 6'd0, 24'd2, 1'b1});
    add_step(0, 0, 0, {1'b0, 48'h0}, 1, {7'd0, 6'd0, 24'd2, 1'b1});
    add_step(0, 0, 0, {1'b1, {4{CMD_STOP, 8'hFF}}}, 1, '0);
    add_step(1, 8'd128, 8'hFF, {1'b1, 48'h0}, 1, '0);
    add_step(0, 0, 0, {1'b0, CMD_BREAK, 8'h63, 36'h0}, 1, {7'd1, 6'd63, 24'd1, 1'b0});
    add_step(0, 0, 0, {1'b0, 12'h0, CMD_BREAK, 8'h64, 24'h0}, 1,
             {7'd2, 6'd0, 24'd2, 1'b0});
    add_step(0, 0, 0, {1'b0, 36'h0, CMD_BREAK, 8'hFA}, 1, {7'd3, 6'd0, 24'd3, 1'b0});
    // jump wraps back onto a visited row: one loop spent
    add_step(0, 0, 0, {1'b0, CMD_JUMP, 8'h00, 36'h0}, 1, {7'd0, 6'd0, 24'd4, 1'b0});
    add_step(0, 0, 0, {1'b0, 24'h0, CMD_JUMP, 8'hFF, 12'h0}, 1,
             {7'd127, 6'd0, 24'd5, 1'b0});
    add_step(0, 0, 0, {1'b0, CMD_EXT, EXT_LOOP, 4'h0, 36'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 12'h0, CMD_STOP, 8'h01, CMD_EXT, 8'h50, CMD_EXT, 8'h70},
             0, '0);
    add_step(0, 0, 0, {1'b0, CMD_EXT, EXT_LOOP, 4'h2, 36'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 48'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 48'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, CMD_EXT, EXT_LOOP, 4'h2, 36'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 48'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 48'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, CMD_EXT, EXT_LOOP, 4'h2, 36'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 12'h0, CMD_EXT, EXT_LOOP, 4'h0, 12'h0, CMD_BREAK, 8'h05},
             0, '0);
    // loop end below its stored start: jump without clearing
    add_step(0, 0, 0, {1'b0, CMD_BREAK, 8'h01, 36'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, 12'h0, CMD_EXT, EXT_LOOP, 4'h1, 24'h0}, 0, '0);
    add_step(0, 0, 0, {1'b0, CMD_STOP, 8'h00, CMD_JUMP, 8'h05, 24'h0}, 0, '0);
    add_step(1, 8'd128, 8'h00, {1'b1, 48'h0}, 1, '0);
    // final stop skips the later jump, row still counts
    add_step(0, 0, 0, {1'b0, CMD_STOP, 8'h00, CMD_JUMP, 8'h10, 24'h0}, 1,
             {7'd0, 6'd1, 24'd1, 1'b1});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_cfg) set_regs(plan[i].len_v, plan[i].lc_v);
      offer(plan[i].stim, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin len_v = 8'd4; lc_v = 8'd2; end
        1: begin len_v = 8'd128; lc_v = 8'd0; end
        2: begin len_v = 8'd0; lc_v = 8'd5; end
        3: begin len_v = 8'd255; lc_v = 8'hC3; end
        4: begin len_v = 8'd1; lc_v = 8'd63; end
        5: begin len_v = 8'd50; lc_v = 8'd50; end
        default: begin
          len_v = $urandom_range(1, 32);
          lc_v = $urandom;
        end
      endcase
      set_regs(len_v, lc_v);
      offer({1'b1, 48'(($urandom << 16) ^ $urandom)}, 0, '0);
      for (int k = 0; k < 250; k++) offer(compose_row(), 0, '0);
    end

    drain();
    repeat (1000) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #250_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
